// ===== src/sjfq_pkg.sv =====
// ----------------------------------------------------------------------------
// SJF ready queue package
// Field widths, codes and shared types of the shortest-job-first ready queue.
// ----------------------------------------------------------------------------
package sjfq_pkg;

  // Payload field widths
  localparam int TID_W      = 6;
  localparam int BURST_W    = 16;
  localparam int KEY_W      = 16;
  localparam int STATUS_W   = 2;

  // Burst estimate: 16 integer bits and 8 fraction bits
  localparam int EST_FRAC_W = 8;
  localparam int EST_W      = BURST_W + EST_FRAC_W;

  // Alpha weight in units of 1/256
  localparam int ALPHA_W    = 9;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  // Multiply-accumulate width
  localparam int ACC_W      = ALPHA_W + EST_W;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = ALPHA_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SJF_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = CFG_IDX_W'(1);
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET  = ALPHA_W'(128);

  // Default queue depth
  localparam int THREAD_COUNT_DEF = 64;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Command to the multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
  } mac_cmd_t;

endpackage

// ===== src/sjfq_ram.sv =====
// ----------------------------------------------------------------------------
// SJF queue generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sjfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sjfq_mac.sv =====
// ----------------------------------------------------------------------------
// SJF queue multiply-accumulate unit
// One 9x24 multiplier feeding a registered accumulator, reused for both
// terms of the exponential burst average.
// ----------------------------------------------------------------------------
module sjfq_mac import sjfq_pkg::*; (
  input  logic               clk_i,
  input  mac_cmd_t           cmd_i,
  input  logic [ALPHA_W-1:0] op_a_i,
  input  logic [EST_W-1:0]   op_b_i,
  output logic [ACC_W-1:0]   acc_o
);

  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] acc_d;
  logic [ACC_W-1:0] acc_q;

  assign prod  = op_a_i * op_b_i;
  assign acc_d = (cmd_i.clr ? '0 : acc_q) + prod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== src/sjf_ready_queue.sv =====
// One item at a time; in a sorted enqueue, the scan and the shift share the queue
// RAM's single read port, and the thread id is first reduced modulo THREAD_COUNT.
// The next item is taken while the last result waits; a stalled result holds the FSM.
// Reset empties the queue and marks every burst estimate as zero at once.
// ----------------------------------------------------------------------------
// SJF ready queue
// Ready queue of thread ids, FIFO or sorted by exponentially averaged burst.
// ----------------------------------------------------------------------------
module sjf_ready_queue import sjfq_pkg::*; #(
  parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [TID_W-1:0]      thread_id_i,
  input  logic [BURST_W-1:0]    last_burst_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [TID_W-1:0]      out_thread_o,
  output logic [KEY_W-1:0]      out_key_o
);

  localparam int IDX_W = $clog2(THREAD_COUNT);
  localparam int CNT_W = $clog2(THREAD_COUNT + 1);
  localparam int PW    = IDX_W + 1;
  localparam int MW    = (TID_W > CNT_W) ? TID_W : CNT_W;
  localparam int ENT_W = TID_W + KEY_W;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_MOD      = 13'b0000000000010,
    S_MUL1     = 13'b0000000000100,
    S_MUL2     = 13'b0000000001000,
    S_EST_WR   = 13'b0000000010000,
    S_SCAN_RD  = 13'b0000000100000,
    S_SCAN_CMP = 13'b0000001000000,
    S_SHIFT_RD = 13'b0000010000000,
    S_SHIFT_WR = 13'b0000100000000,
    S_INSERT   = 13'b0001000000000,
    S_DEQ_RD   = 13'b0010000000000,
    S_DEQ_DONE = 13'b0100000000000,
    S_RESULT   = 13'b1000000000000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [TID_W-1:0]     idx_q, idx_d;
  logic [TID_W-1:0]     tid_q, tid_d;
  logic [BURST_W-1:0]   burst_q, burst_d;
  logic [KEY_W-1:0]     key_q, key_d;
  status_e              res_status_q, res_status_d;
  logic [TID_W-1:0]     res_thread_q, res_thread_d;
  logic [KEY_W-1:0]     res_key_q, res_key_d;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q;
  logic [TID_W-1:0]     out_thread_q;
  logic [KEY_W-1:0]     out_key_q;
  logic                 out_load;

  logic                 sjf_mode_q;
  logic [ALPHA_W-1:0]   alpha_q;
  logic [THREAD_COUNT-1:0] est_vld_q;

  // queue RAM
  logic                 q_we;
  logic [IDX_W-1:0]     q_waddr, q_raddr;
  logic [ENT_W-1:0]     q_wdata, q_rdata;
  logic [KEY_W-1:0]     q_rkey;
  logic [TID_W-1:0]     q_rthread;
  logic [CNT_W-1:0]     rd_off, wr_off;
  logic [PW-1:0]        rd_sum, wr_sum;

  // estimate RAM
  logic                 e_we;
  logic [IDX_W-1:0]     e_addr;
  logic [EST_W-1:0]     e_rdata, e_old, e_new;

  // multiply-accumulate
  mac_cmd_t             mac_cmd;
  logic [ALPHA_W-1:0]   a_eff, mac_a;
  logic [EST_W-1:0]     mac_b;
  logic [ACC_W-1:0]     mac_acc;

  logic                 in_accept;
  logic                 q_full;
  logic [PW-1:0]        head_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign q_full      = (occ_q == CNT_W'(THREAD_COUNT));

  // ---------------------------------------------------------------------------
  // Circular addressing of the queue RAM
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_off = cnt_q;
    wr_off = pos_q;
    unique case (state_q)
      S_SHIFT_RD: rd_off = cnt_q - CNT_W'(1);
      S_DEQ_RD:   rd_off = '0;
      default:    rd_off = cnt_q;
    endcase
    if (state_q == S_SHIFT_WR) begin
      wr_off = cnt_q;
    end
  end

  assign rd_sum  = PW'(head_q) + PW'(rd_off);
  assign wr_sum  = PW'(head_q) + PW'(wr_off);
  assign q_raddr = (rd_sum >= PW'(THREAD_COUNT)) ? IDX_W'(rd_sum - PW'(THREAD_COUNT))
                                                 : IDX_W'(rd_sum);
  assign q_waddr = (wr_sum >= PW'(THREAD_COUNT)) ? IDX_W'(wr_sum - PW'(THREAD_COUNT))
                                                 : IDX_W'(wr_sum);
  assign head_inc = PW'(head_q) + PW'(1);

  assign q_we      = (state_q == S_SHIFT_WR) || (state_q == S_INSERT);
  assign q_wdata   = (state_q == S_INSERT) ? {tid_q, key_q} : q_rdata;
  assign q_rthread = q_rdata[ENT_W-1:KEY_W];
  assign q_rkey    = q_rdata[KEY_W-1:0];

  sjfq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (THREAD_COUNT)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // ---------------------------------------------------------------------------
  // Burst estimate table and its update
  // ---------------------------------------------------------------------------
  assign e_addr = IDX_W'(idx_q);
  assign e_we   = (state_q == S_EST_WR);
  assign e_new  = mac_acc[EST_FRAC_W+EST_W-1:EST_FRAC_W];
  // never-written entries read as zero
  assign e_old  = est_vld_q[e_addr] ? e_rdata : '0;

  sjfq_ram #(
    .WIDTH (EST_W),
    .DEPTH (THREAD_COUNT)
  ) u_est_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_addr),
    .wdata_i (e_new),
    .raddr_i (e_addr),
    .rdata_o (e_rdata)
  );

  assign a_eff       = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign mac_cmd.en  = (state_q == S_MUL1) || (state_q == S_MUL2);
  assign mac_cmd.clr = (state_q == S_MUL1);
  assign mac_a       = (state_q == S_MUL1) ? a_eff : (ALPHA_ONE - a_eff);
  assign mac_b       = (state_q == S_MUL1) ? {burst_q, {EST_FRAC_W{1'b0}}} : e_old;

  sjfq_mac u_mac (
    .clk_i  (clk_i),
    .cmd_i  (mac_cmd),
    .op_a_i (mac_a),
    .op_b_i (mac_b),
    .acc_o  (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    tid_d        = tid_q;
    burst_d      = burst_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_thread_d = res_thread_q;
    res_key_d    = res_key_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          tid_d   = thread_id_i;
          burst_d = last_burst_i;
          idx_d   = thread_id_i;
          if (op_i == OP_DEQ) begin
            if (occ_q == '0) begin
              res_status_d = ST_EMPTY;
              res_thread_d = '0;
              res_key_d    = '0;
              state_d      = S_RESULT;
            end else begin
              state_d = S_DEQ_RD;
            end
          end else if (q_full) begin
            res_status_d = ST_FULL;
            res_thread_d = thread_id_i;
            res_key_d    = '0;
            state_d      = S_RESULT;
          end else if (sjf_mode_q) begin
            state_d = S_MOD;
          end else begin
            // append with key zero
            pos_d   = occ_q;
            key_d   = '0;
            state_d = S_INSERT;
          end
        end
      end
      S_MOD: begin
        // reduce the thread id modulo the table depth
        if (MW'(idx_q) >= MW'(THREAD_COUNT)) begin
          idx_d = idx_q - TID_W'(THREAD_COUNT);
        end else begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        state_d = S_EST_WR;
      end
      S_EST_WR: begin
        key_d   = mac_acc[EST_FRAC_W+EST_W-1:2*EST_FRAC_W];
        cnt_d   = '0;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (cnt_q == occ_q) begin
          pos_d   = occ_q;
          cnt_d   = occ_q;
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        // stop at the first entry with a larger key
        if (q_rkey > key_q) begin
          pos_d   = cnt_q;
          cnt_d   = occ_q;
          state_d = S_SHIFT_RD;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (cnt_q == pos_q) begin
          state_d = S_INSERT;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = S_SHIFT_RD;
      end
      S_INSERT: begin
        occ_d        = occ_q + CNT_W'(1);
        res_status_d = ST_ENQ;
        res_thread_d = tid_q;
        res_key_d    = key_q;
        state_d      = S_RESULT;
      end
      S_DEQ_RD: begin
        state_d = S_DEQ_DONE;
      end
      S_DEQ_DONE: begin
        res_status_d = ST_DEQ;
        res_thread_d = q_rthread;
        res_key_d    = q_rkey;
        occ_d        = occ_q - CNT_W'(1);
        head_d       = (head_inc == PW'(THREAD_COUNT)) ? '0 : IDX_W'(head_inc);
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign out_load    = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_thread_o = out_thread_q;
  assign out_key_o    = out_key_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      est_vld_q   <= '0;
      sjf_mode_q  <= 1'b0;
      alpha_q     <= ALPHA_RESET;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      if (e_we) begin
        est_vld_q[e_addr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SJF_MODE: sjf_mode_q <= cfg_data_i[0];
          CFG_ALPHA:    alpha_q    <= cfg_data_i;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    tid_q        <= tid_d;
    burst_q      <= burst_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_thread_q <= res_thread_d;
    res_key_q    <= res_key_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_thread_q <= res_thread_q;
      out_key_q    <= res_key_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(THREAD_COUNT))
    else $error("occupancy above queue depth");

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |-> !q_full)
    else $error("insert into a full queue");

  a_deq_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEQ_DONE) |=> (occ_q == $past(occ_q - CNT_W'(1))))
    else $error("dequeue did not remove one entry");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == S_RESULT) |=> (state_q == S_RESULT))
    else $error("result dropped while output stalled");

endmodule

// ===== sim/sjf_ready_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SJF ready queue testbench
// Sends enqueue and dequeue words with random gaps and output stalls, runs
// FIFO and shortest-job-first settings, and checks each reply in order
// against a local model of the queue and the per-thread burst estimates.
// ----------------------------------------------------------------------------
module sjf_ready_queue_tb;
  import sjfq_pkg::*;

  localparam int NUM_THREADS = THREAD_COUNT_DEF;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 170;
  localparam int CYCLE_LIMIT = 1_500_000;

  localparam logic [CFG_IDX_W-1:0] CFG_BAD_LO = CFG_ALPHA + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_HI = '1;
  localparam logic [ALPHA_W-1:0]   ALPHA_MAX  = '1;
  localparam logic [ALPHA_W-1:0]   ALPHA_ZERO = '0;
  localparam logic [ALPHA_W-1:0]   ALPHA_MIN  = ALPHA_W'(1);

  typedef struct {
    status_e          status;
    logic [TID_W-1:0] thread;
    logic [KEY_W-1:0] key;
  } reply_t;

  typedef struct {
    logic [TID_W-1:0] thread;
    logic [KEY_W-1:0] key;
  } entry_t;

  class sjf_scoreboard;
    bit                 sjf_on;
    logic [ALPHA_W-1:0] alpha;
    logic [EST_W-1:0]   estimate [NUM_THREADS];
    entry_t             ready_list [$];
    reply_t             due_replies [$];
    int                 mismatches;
    int                 reg_writes;
    int                 status_seen [4];

    function new();
      sjf_on     = 1'b0;
      alpha      = ALPHA_RESET;
      mismatches = 0;
      reg_writes = 0;
      foreach (estimate[i]) estimate[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SJF_MODE) sjf_on = data[0];
      else if (idx == CFG_ALPHA) alpha = data[ALPHA_W-1:0];
      reg_writes++;
    endfunction

    // Exponential average in 16.8 fixed point; alpha above one saturates.
    function logic [EST_W-1:0] averaged_estimate(logic [EST_W-1:0] old,
                                                 logic [BURST_W-1:0] burst);
      longint unsigned one, a, b, o, acc;
      one = ALPHA_ONE;
      a   = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
      b   = burst;
      o   = old;
      acc = a * (b << EST_FRAC_W) + (one - a) * o;
      return EST_W'(acc >> EST_FRAC_W);
    endfunction

    function void accept_cmd(logic op, logic [TID_W-1:0] tid, logic [BURST_W-1:0] burst);
      reply_t r;
      entry_t e;
      int     pos;
      int     i;
      r.thread = '0;
      r.key    = '0;
      if (op == OP_DEQ) begin
        if (ready_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e        = ready_list.pop_front();
          r.status = ST_DEQ;
          r.thread = e.thread;
          r.key    = e.key;
        end
      end else if (ready_list.size() >= NUM_THREADS) begin
        r.status = ST_FULL;
        r.thread = tid;
      end else begin
        e.thread = tid;
        e.key    = '0;
        pos      = ready_list.size();
        if (sjf_on) begin
          estimate[tid] = averaged_estimate(estimate[tid], burst);
          e.key         = estimate[tid][EST_W-1:EST_FRAC_W];
          // place after entries with an equal key
          for (i = 0; i < ready_list.size(); i++) begin
            if (ready_list[i].key > e.key) begin
              pos = i;
              break;
            end
          end
        end
        ready_list.insert(pos, e);
        r.status = ST_ENQ;
        r.thread = tid;
        r.key    = e.key;
      end
      status_seen[r.status]++;
      due_replies.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [TID_W-1:0] thread,
                              logic [KEY_W-1:0] key);
      reply_t r;
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] reply with nothing due: status %0d thread %0d key %0h",
                   $time, status, thread, key);
        return;
      end
      r = due_replies.pop_front();
      if (status !== r.status || thread !== r.thread || key !== r.key) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: status %0d/%0d thread %0d/%0d key %0h/%0h (exp/act)",
                   $time, r.status, status, r.thread, thread, r.key, key);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  op_i;
  logic [TID_W-1:0]      thread_id_i;
  logic [BURST_W-1:0]    last_burst_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [TID_W-1:0]      out_thread_o;
  logic [KEY_W-1:0]      out_key_o;

  sjf_scoreboard board;
  bit            gaps_on;
  int            words_sent;
  int            enq_plan [RAND_PHASES] = '{50, 85, 70, 30, 90, 60, 85, 40};
  bit            mode_plan [RAND_PHASES] = '{1, 1, 1, 0, 1, 1, 0, 1};

  sjf_ready_queue #(
    .THREAD_COUNT (NUM_THREADS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .thread_id_i  (thread_id_i),
    .last_burst_i (last_burst_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_thread_o (out_thread_o),
    .out_key_o    (out_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_word(input logic op, input logic [TID_W-1:0] tid,
                           input logic [BURST_W-1:0] burst);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    thread_id_i  <= tid;
    last_burst_i <= burst;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.accept_cmd(op, tid, burst);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    board.apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and hold until every reply is back.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (board.due_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : reply_sink
    int hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_reply(status_o, out_thread_o, out_key_o);
        hold = gaps_on ? $urandom_range(0, 4) : 0;
      end else if (out_valid_o && hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold > 0);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d replies outstanding", cycles,
             board.due_replies.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int                  p;
    int                  n;
    logic                op;
    logic [TID_W-1:0]    tid;
    logic [BURST_W-1:0]  burst;
    logic [ALPHA_W-1:0]  alpha_pick;
    logic [CFG_DATA_W-1:0] mode_word;

    board        = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OP_ENQ;
    thread_id_i  = '0;
    last_burst_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_SJF_MODE;
    cfg_data_i   = '0;
    gaps_on      = 1'b1;
    words_sent   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // FIFO after reset: empty dequeue, field extremes, then drain past empty
    send_word(OP_DEQ, '0, '0);
    send_word(OP_ENQ, '0, '0);
    send_word(OP_ENQ, '1, '1);
    send_word(OP_ENQ, TID_W'(42), BURST_W'(16'h5555));
    repeat (4) send_word(OP_DEQ, '1, '1);
    drain_replies();

    // Sorted mode, full weight on the last burst; bad indexes must not alias
    cfg_write(CFG_SJF_MODE, '1);
    cfg_write(CFG_BAD_HI, '0);
    cfg_write(CFG_BAD_LO, '0);
    cfg_write(CFG_ALPHA, ALPHA_ONE);
    send_word(OP_ENQ, TID_W'(63), '1);
    send_word(OP_ENQ, TID_W'(1), '0);
    send_word(OP_ENQ, TID_W'(2), BURST_W'(16'h00AA));
    send_word(OP_ENQ, TID_W'(3), BURST_W'(16'h00AA));
    send_word(OP_ENQ, TID_W'(63), '1);
    repeat (5) send_word(OP_DEQ, '0, '0);
    drain_replies();

    // Alpha above one, alpha zero, then a FIFO entry mixed with sorted inserts
    cfg_write(CFG_ALPHA, ALPHA_MAX);
    send_word(OP_ENQ, TID_W'(5), BURST_W'(16'h1234));
    drain_replies();
    cfg_write(CFG_ALPHA, ALPHA_ZERO);
    send_word(OP_ENQ, TID_W'(5), '1);
    drain_replies();
    cfg_write(CFG_SJF_MODE, '0);
    send_word(OP_ENQ, TID_W'(7), '1);
    drain_replies();
    cfg_write(CFG_SJF_MODE, CFG_DATA_W'(1));
    cfg_write(CFG_ALPHA, ALPHA_RESET);
    send_word(OP_ENQ, TID_W'(8), BURST_W'(16'h0100));
    repeat (4) send_word(OP_DEQ, '0, '0);

    // Random phases; the queue carries over so keys from earlier settings mix
    for (p = 0; p < RAND_PHASES; p++) begin
      drain_replies();
      case (p)
        0:       alpha_pick = ALPHA_ZERO;
        1:       alpha_pick = ALPHA_ONE;
        2:       alpha_pick = ALPHA_MAX;
        3:       alpha_pick = ALPHA_MIN;
        default: alpha_pick = ALPHA_W'($urandom_range(0, 511));
      endcase
      // random upper bits, mode in bit zero
      mode_word    = CFG_DATA_W'($urandom);
      mode_word[0] = mode_plan[p];
      cfg_write(CFG_SJF_MODE, mode_word);
      cfg_write(CFG_ALPHA, alpha_pick);
      if (p % 2 == 0)
        cfg_write(CFG_IDX_W'($urandom_range(CFG_BAD_LO, CFG_BAD_HI)), CFG_DATA_W'($urandom));
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n % 32 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        op  = ($urandom_range(0, 99) < enq_plan[p]) ? OP_ENQ : OP_DEQ;
        // a few hot threads so estimates get averaged over many bursts
        tid = ($urandom_range(0, 1) == 0) ? TID_W'($urandom_range(0, 3)) : TID_W'($urandom);
        case ($urandom_range(0, 9))
          0:          burst = '0;
          1:          burst = '1;
          2, 3, 4, 5: burst = BURST_W'($urandom_range(0, 255));
          default:    burst = BURST_W'($urandom);
        endcase
        send_word(op, tid, burst);
      end
    end

    drain_replies();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d words across %0d register writes in FIFO and SJF modes",
             words_sent, board.reg_writes);
    $display("Replies: %0d enqueued, %0d dequeued, %0d empty, %0d full; %0d mismatches",
             board.status_seen[ST_ENQ], board.status_seen[ST_DEQ],
             board.status_seen[ST_EMPTY], board.status_seen[ST_FULL], board.mismatches);
    if (board.mismatches == 0 && board.due_replies.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sjfq_pkg.sv
src/sjfq_ram.sv
src/sjfq_mac.sv
src/sjf_ready_queue.sv
sim/sjf_ready_queue_tb.sv
